[design/vhc_pkg.sv]
// ----------------------------------------------------------------------------
// vhc_pkg
// Shared types and constants of the vote histogram confidence unit.
// ----------------------------------------------------------------------------
`default_nettype none

package vhc_pkg;

  localparam int RD_W = 16;
  localparam int PD_W = 15;
  localparam int PH_W = 14;
  localparam int THR_W = 16;
  localparam int CAND_W = 9;
  localparam int SYM_W = 8;
  localparam int WIN_W = 8;

  localparam logic [1:0] CFG_ROUNDS = 2'd0;
  localparam logic [1:0] CFG_THRESH = 2'd1;
  localparam logic [1:0] CFG_CAND   = 2'd2;

  localparam logic [RD_W-1:0]   ROUNDS_RST = 16'd100;
  localparam logic [THR_W-1:0]  THRESH_RST = 16'd1;
  localparam logic [CAND_W-1:0] CAND_RST   = 9'd256;

  typedef enum logic [1:0] {
    CMD_SAMPLE = 2'd0,
    CMD_CLEAR  = 2'd1,
    CMD_HALVE  = 2'd2,
    CMD_EVAL   = 2'd3
  } vhc_cmd_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MOD,
    ST_RD,
    ST_WR,
    ST_CHK,
    ST_HALVE,
    ST_SCAN,
    ST_MUL,
    ST_DEC,
    ST_EMIT
  } vhc_state_t;

  typedef struct packed {
    logic clr;
    logic push;
    logic mul;
  } vhc_scan_ctl_t;

endpackage

`default_nettype wire

[design/vhc_bin_mem.sv]
// ----------------------------------------------------------------------------
// vhc_bin_mem
// Vote bin storage with one write port and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module vhc_bin_mem #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 32,
  parameter int AW    = 8
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[design/vhc_rem_unit.sv]
// ----------------------------------------------------------------------------
// vhc_rem_unit
// Restoring remainder unit, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module vhc_rem_unit import vhc_pkg::*; (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            start,
  input  wire logic [RD_W-1:0] dividend,
  input  wire logic [PD_W-1:0] divisor,
  output logic                 done,
  output logic      [PH_W-1:0] rem
);

  logic [RD_W-1:0] q_r;
  logic [PH_W-1:0] rem_r;
  logic [4:0]      cnt_r;
  logic            busy_r;
  logic            done_r;
  logic [PD_W-1:0] trial;

  assign trial = {rem_r, q_r[RD_W-1]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == 5'd1);
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 5'(RD_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 5'd1;
        if (cnt_r == 5'd1) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      rem_r <= '0;
    end else if (busy_r) begin
      q_r <= {q_r[RD_W-2:0], 1'b0};
      if (trial >= divisor) begin
        rem_r <= PH_W'(trial - divisor);
      end else begin
        rem_r <= PH_W'(trial);
      end
    end
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

`default_nettype wire

[design/vhc_scan.sv]
// ----------------------------------------------------------------------------
// vhc_scan
// Histogram scan: tracks maximum, runner-up, tie and total over a bin stream,
// then judges whether the maximum is a confident winner.
// ----------------------------------------------------------------------------
`default_nettype none

module vhc_scan import vhc_pkg::*; #(
  parameter int CB = 32,
  parameter int AW = 8,
  parameter int NW = 9
) (
  input  wire logic             clk,
  input  wire vhc_scan_ctl_t    ctl,
  input  wire logic [CB-1:0]    value,
  input  wire logic [AW-1:0]    idx,
  input  wire logic [NW-1:0]    n,
  input  wire logic [THR_W-1:0] threshold,
  output logic                  ok,
  output logic      [AW-1:0]    best
);

  localparam int TW = CB + AW;
  localparam int PW = CB + NW;
  localparam int MW = (CB > THR_W) ? CB : THR_W;

  logic [CB-1:0] top_r;
  logic [CB-1:0] sec_r;
  logic          tie_r;
  logic [AW-1:0] best_r;
  logic [TW-1:0] tot_r;
  logic [PW-1:0] prod_r;
  logic [CB-1:0] half;
  logic          lead_ok;
  logic          avg_fail;

  always_ff @(posedge clk) begin
    if (ctl.clr) begin
      top_r  <= '0;
      sec_r  <= '0;
      tie_r  <= 1'b0;
      best_r <= '0;
      tot_r  <= '0;
    end else if (ctl.push) begin
      tot_r <= tot_r + TW'(value);
      if (value > top_r) begin
        sec_r  <= top_r;
        top_r  <= value;
        best_r <= idx;
        tie_r  <= 1'b0;
      end else if ((value == top_r) && (top_r != '0)) begin
        tie_r <= 1'b1;
      end else if (value > sec_r) begin
        sec_r <= value;
      end
    end
  end

  assign half = (top_r >> 1) + CB'(1);

  always_ff @(posedge clk) begin
    if (ctl.mul) begin
      prod_r <= PW'(half) * PW'(n);
    end
  end

  assign lead_ok  = ((CB+1)'(top_r - sec_r)) >= ((CB+1)'(top_r >> 3) + (CB+1)'(2));
  assign avg_fail = PW'(tot_r) >= prod_r;

  assign ok = (top_r != '0) && (MW'(top_r) >= MW'(threshold)) && !tie_r
              && lead_ok && !avg_fail;
  assign best = best_r;

endmodule

`default_nettype wire

[design/vote_histogram_confidence_unit.sv]
// ----------------------------------------------------------------------------
// vote_histogram_confidence_unit
// Counts symbol samples in saturating vote bins and decides on a winner.
//
// Input items arrive on in_t*: tuser carries the command and the sample
// valid flag, tdata the sample symbol. Result items leave on out_t* from an
// output register, so the next input item is taken while a result waits.
// Registers are written on cfg_* while no item is in work or while the bins are cleared.
// A sample that hits a bin in use reads and rewrites that bin. A check
// walks the bins in use through the single memory read port, n being the
// bins in use; an evaluate walks them too. Halve and clear pass each of
// the MAX_BINS bins through the memory port once. After a write of rounds,
// the first sample recomputes its check phase in a remainder unit that
// retires one bit per cycle.
// After reset a pass zeroes all MAX_BINS bins; inputs are
// held off meanwhile and configuration writes are taken. While the receiver
// stalls, one result is held and the next one waits inside the block.
// ----------------------------------------------------------------------------
`default_nettype none

module vote_histogram_confidence_unit import vhc_pkg::*; #(
  parameter int MAX_BINS   = 256,
  parameter int COUNT_BITS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] sample_value
  input  wire logic [2:0]  in_tuser,   // [1:0] command, [2] sample_valid
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [23:0] out_tdata,  // [7:0] winner, [23:8] rounds_used
  output logic      [0:0]  out_tuser,  // [0] decided
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  localparam int AW = $clog2(MAX_BINS);
  localparam int NW = $clog2(MAX_BINS + 1);
  localparam int SW = (NW > SYM_W) ? NW : SYM_W;
  localparam logic [COUNT_BITS-1:0] CAP = {COUNT_BITS{1'b1}};
  localparam logic [NW-1:0] NMAX = NW'(MAX_BINS);

  vhc_state_t state_r, state_nxt;

  logic [RD_W-1:0]   rounds_r;
  logic [THR_W-1:0]  thr_r;
  logic [CAND_W-1:0] cand_r;
  logic [RD_W-1:0]   round_r;
  logic [PH_W-1:0]   phase_r;
  logic              stale_r;
  logic [NW-1:0]     cnt_r;
  logic              rd_vld_r;
  logic [AW-1:0]     rd_addr_r;
  vhc_cmd_t          cmd_r;
  logic              hit_r;
  logic [AW-1:0]     sym_r;
  logic              res_dec_r;
  logic [WIN_W-1:0]  res_win_r;
  logic [RD_W-1:0]   res_used_r;
  logic              out_tvalid_r;
  logic [23:0]       out_tdata_r;
  logic [0:0]        out_tuser_r;

  logic [NW-1:0]         n;
  logic [PD_W-1:0]       period;
  logic                  accept;
  logic                  in_hit;
  logic                  last;
  logic                  ck;
  logic                  issue;
  logic                  sweep_end;
  logic                  out_free;
  logic                  emit_now;
  logic                  inc_round;
  vhc_cmd_t              in_cmd;

  logic                  mem_we;
  logic [AW-1:0]         mem_waddr;
  logic [COUNT_BITS-1:0] mem_wdata;
  logic                  mem_re;
  logic [AW-1:0]         mem_raddr;
  logic [COUNT_BITS-1:0] mem_rdata;

  vhc_scan_ctl_t         scan_ctl;
  logic                  scan_ok;
  logic [AW-1:0]         scan_best;
  logic                  rem_start;
  logic                  rem_done;
  logic [PH_W-1:0]       rem_val;

  assign n = ((cand_r == '0) || (32'(cand_r) > 32'(MAX_BINS))) ? NMAX : NW'(cand_r);
  assign period = {1'b0, rounds_r[RD_W-1:2]} + PD_W'(1);
  assign accept = in_tvalid && in_tready;
  assign in_cmd = vhc_cmd_t'(in_tuser[1:0]);
  assign in_hit = in_tuser[2] && (SW'(in_tdata) < SW'(n));
  assign last = (rounds_r != '0) && (round_r >= rounds_r - RD_W'(1));
  assign ck = last || ((rounds_r != '0) && (round_r != '0) && (phase_r == '0));
  assign issue = ((state_r == ST_HALVE) && (cnt_r != NMAX))
              || ((state_r == ST_SCAN) && (cnt_r != n));
  assign sweep_end = !rd_vld_r && (((state_r == ST_HALVE) && (cnt_r == NMAX))
              || ((state_r == ST_SCAN) && (cnt_r == n)));
  assign out_free = !out_tvalid_r || out_tready;
  assign emit_now = (cmd_r == CMD_EVAL) || scan_ok || last;
  assign inc_round = (((state_r == ST_WR) || (state_r == ST_CHK)) && !ck)
                  || ((state_r == ST_DEC) && !emit_now);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (cnt_r == NW'(MAX_BINS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          unique case (in_cmd)
            CMD_CLEAR: state_nxt = ST_CLEAR;
            CMD_HALVE: state_nxt = ST_HALVE;
            CMD_EVAL:  state_nxt = ST_SCAN;
            default: begin
              if (stale_r && (rounds_r != '0)) begin
                state_nxt = ST_MOD;
              end else if (in_hit) begin
                state_nxt = ST_RD;
              end else begin
                state_nxt = ST_CHK;
              end
            end
          endcase
        end
      end
      ST_MOD: begin
        if (rem_done) begin
          state_nxt = hit_r ? ST_RD : ST_CHK;
        end
      end
      ST_RD:    state_nxt = ST_WR;
      ST_WR:    state_nxt = ck ? ST_SCAN : ST_IDLE;
      ST_CHK:   state_nxt = ck ? ST_SCAN : ST_IDLE;
      ST_HALVE: state_nxt = sweep_end ? ST_IDLE : ST_HALVE;
      ST_SCAN:  state_nxt = sweep_end ? ST_MUL : ST_SCAN;
      ST_MUL:   state_nxt = ST_DEC;
      ST_DEC:   state_nxt = emit_now ? ST_EMIT : ST_IDLE;
      ST_EMIT:  state_nxt = out_free ? ST_IDLE : ST_EMIT;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready     = (state_r == ST_IDLE);
    cfg_ready     = (state_r == ST_IDLE) || (state_r == ST_CLEAR);
    rem_start     = (state_r == ST_IDLE) && (state_nxt == ST_MOD);
    scan_ctl.clr  = (state_r == ST_IDLE) || (state_r == ST_WR) || (state_r == ST_CHK);
    scan_ctl.push = (state_r == ST_SCAN) && rd_vld_r;
    scan_ctl.mul  = (state_r == ST_MUL);
    mem_we    = 1'b0;
    mem_waddr = cnt_r[AW-1:0];
    mem_wdata = '0;
    mem_re    = issue;
    mem_raddr = cnt_r[AW-1:0];
    unique case (state_r)
      ST_CLEAR: begin
        mem_we = 1'b1;
      end
      ST_RD: begin
        mem_re    = 1'b1;
        mem_raddr = sym_r;
      end
      ST_WR: begin
        mem_we    = (mem_rdata != CAP);
        mem_waddr = sym_r;
        mem_wdata = mem_rdata + COUNT_BITS'(1);
      end
      ST_HALVE: begin
        mem_we    = rd_vld_r;
        mem_waddr = rd_addr_r;
        mem_wdata = mem_rdata >> 1;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      cnt_r        <= '0;
      rd_vld_r     <= 1'b0;
      round_r      <= '0;
      phase_r      <= '0;
      stale_r      <= 1'b0;
      rounds_r     <= ROUNDS_RST;
      thr_r        <= THRESH_RST;
      cand_r       <= CAND_RST;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      rd_vld_r <= issue;
      if (state_r == ST_IDLE) begin
        cnt_r <= '0;
      end else if ((state_r == ST_CLEAR) || issue) begin
        cnt_r <= cnt_r + NW'(1);
      end
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_ROUNDS: begin
            rounds_r <= cfg_data;
            stale_r  <= 1'b1;
          end
          CFG_THRESH: thr_r  <= cfg_data;
          CFG_CAND:   cand_r <= cfg_data[CAND_W-1:0];
          default:    rounds_r <= rounds_r;
        endcase
      end
      if (accept && (in_cmd == CMD_CLEAR)) begin
        round_r <= '0;
        phase_r <= '0;
      end
      if ((state_r == ST_MOD) && rem_done) begin
        phase_r <= rem_val;
        stale_r <= 1'b0;
      end
      if (inc_round && (round_r != '1)) begin
        round_r <= round_r + RD_W'(1);
        phase_r <= ((PD_W'(phase_r) + PD_W'(1)) == period) ? '0 : phase_r + PH_W'(1);
      end
      if ((state_r == ST_DEC) && emit_now && (cmd_r == CMD_SAMPLE)) begin
        round_r <= '0;
        phase_r <= '0;
      end
      if ((state_r == ST_EMIT) && out_free) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_addr_r <= cnt_r[AW-1:0];
    if (accept) begin
      cmd_r <= in_cmd;
      hit_r <= in_hit;
      sym_r <= AW'(in_tdata);
    end
    if (state_r == ST_DEC) begin
      res_dec_r  <= scan_ok;
      res_win_r  <= scan_ok ? WIN_W'(scan_best) : '0;
      res_used_r <= (cmd_r == CMD_EVAL) ? round_r : round_r + RD_W'(1);
    end
    if ((state_r == ST_EMIT) && out_free) begin
      out_tuser_r <= res_dec_r;
      out_tdata_r <= {res_used_r, res_win_r};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  vhc_bin_mem #(
    .DEPTH (MAX_BINS),
    .WIDTH (COUNT_BITS),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  vhc_rem_unit u_rem (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (rem_start),
    .dividend (round_r),
    .divisor  (period),
    .done     (rem_done),
    .rem      (rem_val)
  );

  vhc_scan #(
    .CB (COUNT_BITS),
    .AW (AW),
    .NW (NW)
  ) u_scan (
    .clk       (clk),
    .ctl       (scan_ctl),
    .value     (mem_rdata),
    .idx       (rd_addr_r),
    .n         (n),
    .threshold (thr_r),
    .ok        (scan_ok),
    .best      (scan_best)
  );

endmodule

`default_nettype wire
